@@ hw/rtl/pte_pkg.sv @@
// Shared types and constants of the pass timing moving average table.
`timescale 1ns / 1ps
package pte_pkg;

  localparam int KEY_W       = 16;
  localparam int TICK_W      = 64;
  localparam int FREQ_W      = 34;
  localparam int WIN_W       = 32;
  localparam int MS_W        = 32;
  localparam int STAT_W      = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 34;

  // diff * 1000 fits in 74 bits; Q16.16 scaling appends 16 zero bits
  localparam int SCALED_W    = TICK_W + 10;
  localparam int RAW_DVD_W   = SCALED_W + 16;
  localparam int ALPHA_W     = 17;
  localparam int ALPHA_DVD_W = WIN_W + 16;
  localparam int PROD_W      = MS_W + ALPHA_W;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;
  localparam logic [MS_W-1:0]    MS_MAX    = 32'hFFFF_FFFF;

  localparam logic [STAT_W-1:0] STAT_UPDATED  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_INSERTED = 2'd1;
  localparam logic [STAT_W-1:0] STAT_DROPPED  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_SKIPPED  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_FREQ   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'b1;

  typedef struct packed {
    logic load;
    logic diff;
    logic scale_a;
    logic scale_b;
    logic div_start;
    logic srch_start;
    logic rd_avg;
    logic mul;
    logic wr_upd;
    logic wr_ins;
    logic res_skip;
    logic res_drop;
    logic out_load;
  } pte_cmd_t;

  typedef struct packed {
    logic skip;
    logic busy;
    logic hit;
    logic full;
  } pte_stat_t;

endpackage

@@ hw/rtl/pass_timing_ema_table_unit.sv @@
// Top level of the keyed moving average table for pass timings.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   key, start/stop ticks, complete, frame dt, last
//   out_     output     out_valid / out_ready key, raw ms, smoothed ms, status, last
//   cfg_     input      cfg_we                cfg_index, cfg_wdata (34 bit)
//
// One transaction at a time; a skipped pass goes from the latch through the difference state
// to the output register. A measured pass runs the tick difference, the scale steps and the
// divider start, then waits while the 90-step raw-time divider and the key search run side
// by side (the search ends at the match on a hit, after all entries on a miss), then drops,
// inserts, or reads, blends and writes back. Synchronous reset clears the entry count.
// A new transaction is taken while a result waits; only the hand-off stalls on out_ready.
`timescale 1ns / 1ps
module pass_timing_ema_table_unit #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [pte_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pte_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // input transactions
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pte_pkg::KEY_W-1:0]         in_pass_key,
  input  logic [pte_pkg::TICK_W-1:0]        in_start_tick,
  input  logic [pte_pkg::TICK_W-1:0]        in_stop_tick,
  input  logic                              in_pass_complete,
  input  logic [pte_pkg::MS_W-1:0]          in_frame_dt_ms,
  input  logic                              in_frame_last_in,
  // result transactions
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pte_pkg::KEY_W-1:0]         out_result_key,
  output logic [pte_pkg::MS_W-1:0]          out_raw_ms,
  output logic [pte_pkg::MS_W-1:0]          out_smoothed_ms,
  output logic [pte_pkg::STAT_W-1:0]        out_status,
  output logic                              out_frame_last_out
);

  // configuration registers; zero frequency turns measuring off
  logic [pte_pkg::FREQ_W-1:0] freq_r;
  logic [pte_pkg::WIN_W-1:0]  window_r;

  pte_pkg::pte_cmd_t  cmd;
  pte_pkg::pte_stat_t stat;

  // Drop writes to indexes that name no register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r   <= '0;
      window_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        pte_pkg::CFG_FREQ:   freq_r   <= cfg_wdata;
        pte_pkg::CFG_WINDOW: window_r <= cfg_wdata[pte_pkg::WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequence: latch, tick difference, scale by 1000 in two subtract steps,
  // start both dividers, wait with the key search, then update, insert or drop; a skip ends after the difference.
  pte_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pte_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .freq              (freq_r),
    .window            (window_r),
    .in_pass_key       (in_pass_key),
    .in_start_tick     (in_start_tick),
    .in_stop_tick      (in_stop_tick),
    .in_pass_complete  (in_pass_complete),
    .in_frame_dt_ms    (in_frame_dt_ms),
    .in_frame_last_in  (in_frame_last_in),
    .out_result_key    (out_result_key),
    .out_raw_ms        (out_raw_ms),
    .out_smoothed_ms   (out_smoothed_ms),
    .out_status        (out_status),
    .out_frame_last_out(out_frame_last_out)
  );

endmodule

@@ hw/rtl/pte_div.sv @@
// Restoring divider, one quotient bit per cycle, with quotient overflow flag.
`timescale 1ns / 1ps
module pte_div #(
  parameter int DVD_W = 48,
  parameter int DSR_W = 32,
  parameter int QUO_W = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  output logic             busy,
  output logic [QUO_W-1:0] quotient,
  output logic             overflow
);

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] dvd_r;
  logic [DSR_W-1:0] dsr_r;
  logic [DSR_W-1:0] rem_r;
  logic [QUO_W-1:0] quo_r;
  logic             ovf_r;

  logic [DSR_W:0]   trial;
  logic             ge;
  logic [DSR_W-1:0] rem_nxt;

  assign trial   = {rem_r, dvd_r[DVD_W-1]};
  assign ge      = trial >= {1'b0, dsr_r};
  assign rem_nxt = ge ? DSR_W'(trial - {1'b0, dsr_r}) : trial[DSR_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == CNT_W'(DVD_W - 1)) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
      ovf_r <= 1'b0;
      cnt_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[QUO_W-2:0], ge};
      ovf_r <= ovf_r | quo_r[QUO_W-1];
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;
  assign overflow = ovf_r;

endmodule

@@ hw/rtl/pte_datapath.sv @@
// Datapath: tick scaling, two dividers, key table, blend and result registers.
`timescale 1ns / 1ps
module pte_datapath #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pte_pkg::pte_cmd_t                 cmd,
  output pte_pkg::pte_stat_t                stat,
  input  logic [pte_pkg::FREQ_W-1:0]        freq,
  input  logic [pte_pkg::WIN_W-1:0]         window,
  input  logic [pte_pkg::KEY_W-1:0]         in_pass_key,
  input  logic [pte_pkg::TICK_W-1:0]        in_start_tick,
  input  logic [pte_pkg::TICK_W-1:0]        in_stop_tick,
  input  logic                              in_pass_complete,
  input  logic [pte_pkg::MS_W-1:0]          in_frame_dt_ms,
  input  logic                              in_frame_last_in,
  output logic [pte_pkg::KEY_W-1:0]         out_result_key,
  output logic [pte_pkg::MS_W-1:0]          out_raw_ms,
  output logic [pte_pkg::MS_W-1:0]          out_smoothed_ms,
  output logic [pte_pkg::STAT_W-1:0]        out_status,
  output logic                              out_frame_last_out
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // latched transaction
  logic [pte_pkg::KEY_W-1:0]    key_r;
  logic [pte_pkg::TICK_W-1:0]   start_r;
  logic [pte_pkg::TICK_W-1:0]   stop_r;
  logic                         cmpl_r;
  logic [pte_pkg::MS_W-1:0]     dt_r;
  logic                         last_r;

  logic [pte_pkg::TICK_W-1:0]   diff_r;
  logic [pte_pkg::SCALED_W-1:0] scaled_r;

  // dividers
  logic                         raw_busy, raw_ovf;
  logic [pte_pkg::MS_W-1:0]     raw_quo;
  logic                         a_busy, a_ovf;
  logic [pte_pkg::ALPHA_W-1:0]  a_quo;
  logic [pte_pkg::MS_W-1:0]     raw_val;
  logic [pte_pkg::ALPHA_W-1:0]  alpha_val;

  // table
  logic [pte_pkg::KEY_W-1:0]    key_mem_r [TABLE_DEPTH];
  logic [pte_pkg::MS_W-1:0]     avg_mem_r [TABLE_DEPTH];
  logic [CNT_W-1:0]             cnt_r;
  logic [CNT_W-1:0]             srch_idx_r;
  logic                         srch_act_r;
  logic                         q_vld_r;
  logic [IDX_W-1:0]             q_idx_r;
  logic [pte_pkg::KEY_W-1:0]    key_q_r;
  logic                         hit_r;
  logic [IDX_W-1:0]             hit_idx_r;
  logic                         match;
  logic                         issue;
  logic [pte_pkg::MS_W-1:0]     avg_q_r;

  // blend
  logic                         ge_r;
  logic [pte_pkg::PROD_W-1:0]   prod_r;
  logic [pte_pkg::MS_W-1:0]     abs_diff;
  logic [pte_pkg::MS_W-1:0]     step;
  logic [pte_pkg::MS_W-1:0]     avg_new;

  // results
  logic [pte_pkg::MS_W-1:0]     res_raw_r;
  logic [pte_pkg::MS_W-1:0]     res_avg_r;
  logic [pte_pkg::STAT_W-1:0]   res_status_r;
  logic [pte_pkg::KEY_W-1:0]    out_key_r;
  logic [pte_pkg::MS_W-1:0]     out_raw_r;
  logic [pte_pkg::MS_W-1:0]     out_avg_r;
  logic [pte_pkg::STAT_W-1:0]   out_status_r;
  logic                         out_last_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r   <= in_pass_key;
      start_r <= in_start_tick;
      stop_r  <= in_stop_tick;
      cmpl_r  <= in_pass_complete;
      dt_r    <= in_frame_dt_ms;
      last_r  <= in_frame_last_in;
    end
    if (cmd.diff) begin
      diff_r <= stop_r - start_r;
    end
    // diff * 1000 = diff * 1024 - diff * 16 - diff * 8
    if (cmd.scale_a) begin
      scaled_r <= {diff_r, 10'b0} - {6'b0, diff_r, 4'b0};
    end
    if (cmd.scale_b) begin
      scaled_r <= scaled_r - {7'b0, diff_r, 3'b0};
    end
  end

  pte_div #(
    .DVD_W(pte_pkg::RAW_DVD_W),
    .DSR_W(pte_pkg::FREQ_W),
    .QUO_W(pte_pkg::MS_W)
  ) u_raw_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .dividend({scaled_r, 16'b0}),
    .divisor (freq),
    .busy    (raw_busy),
    .quotient(raw_quo),
    .overflow(raw_ovf)
  );

  pte_div #(
    .DVD_W(pte_pkg::ALPHA_DVD_W),
    .DSR_W(pte_pkg::WIN_W),
    .QUO_W(pte_pkg::ALPHA_W)
  ) u_alpha_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .dividend({dt_r, 16'b0}),
    .divisor (window),
    .busy    (a_busy),
    .quotient(a_quo),
    .overflow(a_ovf)
  );

  assign raw_val   = raw_ovf ? pte_pkg::MS_MAX : raw_quo;
  assign alpha_val = (window == '0 || a_ovf || a_quo > pte_pkg::ALPHA_ONE) ?
                     pte_pkg::ALPHA_ONE : a_quo;

  // linear key search, one entry per cycle, compare in the cycle after the read
  assign match = q_vld_r && (key_q_r == key_r);
  assign issue = srch_idx_r < cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srch_act_r <= 1'b0;
      q_vld_r    <= 1'b0;
      hit_r      <= 1'b0;
    end else if (cmd.srch_start) begin
      srch_act_r <= 1'b1;
      q_vld_r    <= 1'b0;
      hit_r      <= 1'b0;
    end else if (srch_act_r) begin
      if (match) begin
        hit_r      <= 1'b1;
        srch_act_r <= 1'b0;
        q_vld_r    <= 1'b0;
      end else if (issue) begin
        q_vld_r <= 1'b1;
      end else begin
        q_vld_r <= 1'b0;
        if (!q_vld_r) begin
          srch_act_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.srch_start) begin
      srch_idx_r <= '0;
    end else if (srch_act_r && issue) begin
      srch_idx_r <= srch_idx_r + CNT_W'(1);
    end
    q_idx_r <= srch_idx_r[IDX_W-1:0];
    if (srch_act_r && match) begin
      hit_idx_r <= q_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.wr_ins) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  // key memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_ins) begin
      key_mem_r[cnt_r[IDX_W-1:0]] <= key_r;
    end
    key_q_r <= key_mem_r[srch_idx_r[IDX_W-1:0]];
  end

  // average memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_ins) begin
      avg_mem_r[cnt_r[IDX_W-1:0]] <= raw_val;
    end else if (cmd.wr_upd) begin
      avg_mem_r[hit_idx_r] <= avg_new;
    end
    if (cmd.rd_avg) begin
      avg_q_r <= avg_mem_r[hit_idx_r];
    end
  end

  assign abs_diff = (raw_val >= avg_q_r) ? raw_val - avg_q_r : avg_q_r - raw_val;
  // alpha never exceeds one, so the product stays below 2^48
  assign step     = prod_r[pte_pkg::MS_W+15:16];
  assign avg_new  = ge_r ? avg_q_r + step : avg_q_r - step;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      ge_r   <= raw_val >= avg_q_r;
      prod_r <= pte_pkg::PROD_W'(abs_diff) * pte_pkg::PROD_W'(alpha_val);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_skip) begin
      res_raw_r    <= '0;
      res_avg_r    <= '0;
      res_status_r <= pte_pkg::STAT_SKIPPED;
    end else if (cmd.res_drop) begin
      res_raw_r    <= raw_val;
      res_avg_r    <= '0;
      res_status_r <= pte_pkg::STAT_DROPPED;
    end else if (cmd.wr_ins) begin
      res_raw_r    <= raw_val;
      res_avg_r    <= raw_val;
      res_status_r <= pte_pkg::STAT_INSERTED;
    end else if (cmd.wr_upd) begin
      res_raw_r    <= raw_val;
      res_avg_r    <= avg_new;
      res_status_r <= pte_pkg::STAT_UPDATED;
    end
    if (cmd.out_load) begin
      out_key_r    <= key_r;
      out_raw_r    <= res_raw_r;
      out_avg_r    <= res_avg_r;
      out_status_r <= res_status_r;
      out_last_r   <= last_r;
    end
  end

  assign stat.skip = !cmpl_r || (freq == '0);
  assign stat.busy = raw_busy || a_busy || srch_act_r;
  assign stat.hit  = hit_r;
  assign stat.full = cnt_r == CNT_W'(TABLE_DEPTH);

  assign out_result_key     = out_key_r;
  assign out_raw_ms         = out_raw_r;
  assign out_smoothed_ms    = out_avg_r;
  assign out_status         = out_status_r;
  assign out_frame_last_out = out_last_r;

endmodule

@@ hw/rtl/pte_ctrl.sv @@
// Controller state machine: sequences one transaction through the datapath.
`timescale 1ns / 1ps
module pte_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  pte_pkg::pte_stat_t stat,
  output pte_pkg::pte_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DIFF    = 4'd1;
  localparam logic [3:0] S_SCALE_A = 4'd2;
  localparam logic [3:0] S_SCALE_B = 4'd3;
  localparam logic [3:0] S_START   = 4'd4;
  localparam logic [3:0] S_WAIT    = 4'd5;
  localparam logic [3:0] S_RDAVG   = 4'd6;
  localparam logic [3:0] S_MUL     = 4'd7;
  localparam logic [3:0] S_UPD     = 4'd8;
  localparam logic [3:0] S_INS     = 4'd9;
  localparam logic [3:0] S_FIN     = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.diff = 1'b1;
        if (stat.skip) begin
          cmd.res_skip = 1'b1;
          state_nxt    = S_FIN;
        end else begin
          cmd.srch_start = 1'b1;
          state_nxt      = S_SCALE_A;
        end
      end
      S_SCALE_A: begin
        cmd.scale_a = 1'b1;
        state_nxt   = S_SCALE_B;
      end
      S_SCALE_B: begin
        cmd.scale_b = 1'b1;
        state_nxt   = S_START;
      end
      S_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_WAIT;
      end
      S_WAIT: begin
        if (!stat.busy) begin
          if (stat.hit) begin
            state_nxt = S_RDAVG;
          end else if (!stat.full) begin
            state_nxt = S_INS;
          end else begin
            cmd.res_drop = 1'b1;
            state_nxt    = S_FIN;
          end
        end
      end
      S_RDAVG: begin
        cmd.rd_avg = 1'b1;
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.wr_upd = 1'b1;
        state_nxt  = S_FIN;
      end
      S_INS: begin
        cmd.wr_ins = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ hw/rtl/pte_checker.sv @@
// Port-level checker for the pass timing moving average table, with its bind.
`timescale 1ns / 1ps
module pte_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [pte_pkg::KEY_W-1:0]  out_result_key,
  input logic [pte_pkg::MS_W-1:0]   out_raw_ms,
  input logic [pte_pkg::MS_W-1:0]   out_smoothed_ms,
  input logic [pte_pkg::STAT_W-1:0] out_status,
  input logic                       out_frame_last_out
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_key) &&
      $stable(out_raw_ms) && $stable(out_smoothed_ms) && $stable(out_status) &&
      $stable(out_frame_last_out))
    else $error("stalled result changed");

  a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == pte_pkg::STAT_SKIPPED |->
      out_raw_ms == '0 && out_smoothed_ms == '0)
    else $error("skipped pass carries timing values");

  a_insert_avg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == pte_pkg::STAT_INSERTED |-> out_smoothed_ms == out_raw_ms)
    else $error("inserted key average differs from raw time");

  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == pte_pkg::STAT_DROPPED |-> out_smoothed_ms == '0)
    else $error("dropped key carries an average");

endmodule

bind pass_timing_ema_table_unit pte_checker u_pte_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_result_key    (out_result_key),
  .out_raw_ms        (out_raw_ms),
  .out_smoothed_ms   (out_smoothed_ms),
  .out_status        (out_status),
  .out_frame_last_out(out_frame_last_out)
);

@@ tb/tb_top.sv @@
// Self-checking testbench for the keyed pass timing moving average table.
`timescale 1ns / 1ps
module tb_top;
  import pte_pkg::*;

  localparam int TABLE_SLOTS   = 128;
  localparam int KEY_POOL_SIZE = 100;
  localparam int RUN_LIMIT     = 1000000;

  typedef struct {
    logic [KEY_W-1:0]  key;
    logic [TICK_W-1:0] start_tick;
    logic [TICK_W-1:0] stop_tick;
    logic              complete;
    logic [MS_W-1:0]   frame_dt;
    logic              last;
  } pass_item_t;

  typedef struct {
    logic [KEY_W-1:0]  key;
    logic [MS_W-1:0]   raw_ms;
    logic [MS_W-1:0]   smoothed_ms;
    logic [STAT_W-1:0] status;
    logic              last;
  } pass_timing_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_FREQ;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [KEY_W-1:0]      in_pass_key = '0;
  logic [TICK_W-1:0]     in_start_tick = '0;
  logic [TICK_W-1:0]     in_stop_tick = '0;
  logic                  in_pass_complete = 1'b0;
  logic [MS_W-1:0]       in_frame_dt_ms = '0;
  logic                  in_frame_last_in = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [KEY_W-1:0]      out_result_key;
  logic [MS_W-1:0]       out_raw_ms;
  logic [MS_W-1:0]       out_smoothed_ms;
  logic [STAT_W-1:0]     out_status;
  logic                  out_frame_last_out;

  // Stimulus and scoreboard state.
  pass_item_t   pending_passes[$];
  pass_timing_t expected_timings[$];
  pass_item_t   on_bus;
  logic         full_rate = 1'b0;
  int           error_count = 0;
  int           cycle_count = 0;
  logic [KEY_W-1:0] key_pool[KEY_POOL_SIZE];

  // Mirror of the block: configuration and the key table.
  logic [FREQ_W-1:0] tick_hz = '0;
  logic [WIN_W-1:0]  window_q16 = '0;
  logic [KEY_W-1:0]  slot_keys[TABLE_SLOTS];
  logic [MS_W-1:0]   slot_avgs[TABLE_SLOTS];
  int                slots_used = 0;

  pass_timing_ema_table_unit #(
    .TABLE_DEPTH(TABLE_SLOTS)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_pass_key       (in_pass_key),
    .in_start_tick     (in_start_tick),
    .in_stop_tick      (in_stop_tick),
    .in_pass_complete  (in_pass_complete),
    .in_frame_dt_ms    (in_frame_dt_ms),
    .in_frame_last_in  (in_frame_last_in),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_key    (out_result_key),
    .out_raw_ms        (out_raw_ms),
    .out_smoothed_ms   (out_smoothed_ms),
    .out_status        (out_status),
    .out_frame_last_out(out_frame_last_out)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Tick span to Q16.16 ms: floor(span * 1000 * 65536 / hz), clipped to 32 bits.
  // A 128-bit quotient keeps the whole product exact.
  function automatic logic [MS_W-1:0] ticks_to_q16ms(input logic [TICK_W-1:0] span,
                                                     input logic [FREQ_W-1:0] hz);
    logic [127:0] quo;
    quo = ({64'd0, span} * 128'd65536000) / {94'd0, hz};
    return (quo > {96'd0, MS_MAX}) ? MS_MAX : quo[MS_W-1:0];
  endfunction

  // Smoothing factor in Q1.16, one when the window is zero or the frame is longer.
  function automatic logic [ALPHA_W-1:0] alpha_q16(input logic [MS_W-1:0] dt,
                                                  input logic [WIN_W-1:0] win);
    logic [63:0] q;
    if (win == '0) return ALPHA_ONE;
    q = {16'd0, dt, 16'd0} / {32'd0, win};
    return (q > {47'd0, ALPHA_ONE}) ? ALPHA_ONE : q[ALPHA_W-1:0];
  endfunction

  // Move the average toward the new sample; the step magnitude is truncated.
  function automatic logic [MS_W-1:0] blend_toward(input logic [MS_W-1:0] avg,
                                                   input logic [MS_W-1:0] raw,
                                                   input logic [ALPHA_W-1:0] a);
    logic [63:0] step;
    if (raw >= avg) begin
      step = ({32'd0, raw - avg} * {47'd0, a}) >> 16;
      return avg + step[MS_W-1:0];
    end
    step = ({32'd0, avg - raw} * {47'd0, a}) >> 16;
    return avg - step[MS_W-1:0];
  endfunction

  // Work out the result of one accepted pass and update the mirrored table.
  task automatic predict_timing(input pass_item_t p);
    pass_timing_t       r;
    logic [ALPHA_W-1:0] a;
    int                 slot;
    int                 i;
    r.key         = p.key;
    r.last        = p.last;
    r.raw_ms      = '0;
    r.smoothed_ms = '0;
    if (!p.complete || tick_hz == '0) begin
      r.status = STAT_SKIPPED;
    end else begin
      r.raw_ms = ticks_to_q16ms(p.stop_tick - p.start_tick, tick_hz);
      a = alpha_q16(p.frame_dt, window_q16);
      slot = -1;
      for (i = 0; i < slots_used; i++) begin
        if (slot < 0 && slot_keys[i] == p.key) slot = i;
      end
      if (slot >= 0) begin
        slot_avgs[slot] = blend_toward(slot_avgs[slot], r.raw_ms, a);
        r.smoothed_ms   = slot_avgs[slot];
        r.status        = STAT_UPDATED;
      end else if (slots_used < TABLE_SLOTS) begin
        slot_keys[slots_used] = p.key;
        slot_avgs[slots_used] = r.raw_ms;
        slots_used++;
        r.smoothed_ms = r.raw_ms;
        r.status      = STAT_INSERTED;
      end else begin
        // table full: new key is dropped but the measurement still reported
        r.status = STAT_DROPPED;
      end
    end
    expected_timings.push_back(r);
  endtask

  task automatic flag_error(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    error_count++;
  endtask

  task automatic compare_field(input string name, input logic [MS_W-1:0] got,
                               input logic [MS_W-1:0] want);
    if (got !== want) flag_error($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // Driver: present queued passes, hold each one until accepted, and predict
  // the result at the edge of acceptance.
  always @(posedge clk) begin : drive_passes
    pass_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_timing(on_bus);
      if (!in_valid || in_ready) begin
        if (pending_passes.size() != 0 && (full_rate || $urandom_range(0, 99) >= 7)) begin
          nxt = pending_passes.pop_front();
          on_bus           <= nxt;
          in_pass_key      <= nxt.key;
          in_start_tick    <= nxt.start_tick;
          in_stop_tick     <= nxt.stop_tick;
          in_pass_complete <= nxt.complete;
          in_frame_dt_ms   <= nxt.frame_dt;
          in_frame_last_in <= nxt.last;
          in_valid         <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transaction with the oldest expectation and
  // stall the output side at random.
  always @(posedge clk) begin : watch_results
    pass_timing_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_timings.size() == 0) begin
          flag_error($sformatf("unexpected result for key %0h", out_result_key));
        end else begin
          want = expected_timings.pop_front();
          compare_field("key", {16'd0, out_result_key}, {16'd0, want.key});
          compare_field("raw_ms", out_raw_ms, want.raw_ms);
          compare_field("smoothed_ms", out_smoothed_ms, want.smoothed_ms);
          compare_field("status", {30'd0, out_status}, {30'd0, want.status});
          compare_field("frame_last", {31'd0, out_frame_last_out}, {31'd0, want.last});
        end
      end
      out_ready <= full_rate || ($urandom_range(0, 99) >= 7);
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic queue_pass(input logic [KEY_W-1:0] key, input logic [TICK_W-1:0] t0,
                            input logic [TICK_W-1:0] t1, input logic complete,
                            input logic [MS_W-1:0] dt, input logic last);
    pass_item_t p;
    p = '{key, t0, t1, complete, dt, last};
    pending_passes.push_back(p);
  endtask

  // Random passes shaped by the current setting: mostly spans that land in the
  // unsaturated range and frame times inside the window, keys mostly from a
  // fixed pool so entries get revisited, with wraps and saturation mixed in.
  task automatic queue_random_passes(input int count);
    logic [KEY_W-1:0]  key;
    logic [TICK_W-1:0] t0;
    logic [TICK_W-1:0] span;
    logic [TICK_W-1:0] bound;
    logic [MS_W-1:0]   dt;
    int                pick;
    int                n;
    for (n = 0; n < count; n++) begin
      key = ($urandom_range(0, 99) < 80) ? key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)]
                                         : KEY_W'($urandom);
      bound = 64'(tick_hz) * 64'd66 + 64'd1;
      pick = $urandom_range(0, 99);
      if (pick < 70)      span = rand64() % bound;
      else if (pick < 85) span = rand64() % 64'd4096;
      else                span = rand64();
      if (window_q16 != '0 && $urandom_range(0, 99) < 75) dt = $urandom_range(0, window_q16);
      else                                                dt = $urandom;
      t0 = rand64();
      queue_pass(key, t0, t0 + span, $urandom_range(0, 99) < 90, dt,
                 $urandom_range(0, 7) == 0);
    end
  endtask

  // Block until every queued pass went in and every result came back.
  task automatic wait_drained();
    while (pending_passes.size() != 0 || in_valid || expected_timings.size() != 0)
      @(posedge clk);
  endtask

  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_FREQ:   tick_hz    = val[FREQ_W-1:0];
      CFG_WINDOW: window_q16 = val[WIN_W-1:0];
      default: ;
    endcase
  endtask

  // Reprogram only while idle: drain first, then write both registers.
  task automatic start_phase(input logic [FREQ_W-1:0] hz, input logic [WIN_W-1:0] win,
                             input logic no_idle);
    wait_drained();
    program_reg(CFG_FREQ, CFG_DATA_W'(hz));
    program_reg(CFG_WINDOW, CFG_DATA_W'(win));
    full_rate <= no_idle;
  endtask

  initial begin : run_sequence
    int i;
    for (i = 0; i < KEY_POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Registers at reset: frequency zero skips even complete passes.
    queue_pass(16'hFFFF, '1, 64'd0, 1'b1, 32'hFFFF_FFFF, 1'b1);
    queue_pass(16'h0000, 64'd0, 64'd100, 1'b0, 32'd0, 1'b0);

    // 1 MHz ticks, zero window: alpha of one, so the average follows the sample.
    start_phase(34'd1000000, 32'd0, 1'b0);
    queue_pass(16'h0000, 64'd5000, 64'd6000, 1'b1, 32'h0001_0000, 1'b0);
    queue_pass(16'h0000, 64'd0, 64'd2000, 1'b1, 32'h0001_0000, 1'b1);
    queue_pass(16'h0000, 64'd0, 64'd3000, 1'b0, 32'd0, 1'b0);
    queue_pass(16'h8001, 64'd0, '1, 1'b1, 32'd0, 1'b0);
    queue_pass(16'h8001, 64'hFFFF_FFFF_FFFF_FFF6, 64'd10, 1'b1, 32'd0, 1'b1);

    // Fastest clock, 16 ms window: zero alpha, clamped alpha, partial steps both ways,
    // and a span just under the saturation point.
    start_phase('1, 32'h0010_0000, 1'b0);
    queue_pass(16'h0000, 64'd100, 64'd100, 1'b1, 32'd0, 1'b0);
    queue_pass(16'h0000, 64'd0, 64'd0, 1'b1, 32'h0020_0000, 1'b0);
    queue_pass(16'h0000, 64'd0, 64'h3_FFFF_FFFF, 1'b1, 32'h0004_0000, 1'b0);
    queue_pass(16'h0000, 64'd0, 64'd0, 1'b1, 32'h0008_0000, 1'b1);
    queue_pass(16'h7FFE, 64'd0, 64'd17179869183 * 64'd65 + 64'd8589934591, 1'b1,
               32'h0001_0000, 1'b0);

    // One tick per second, widest window: largest unsaturated value, then overflow.
    start_phase(34'd1, '1, 1'b0);
    queue_pass(16'h0002, 64'd0, 64'd65, 1'b1, 32'hFFFF_FFFF, 1'b0);
    queue_pass(16'h0002, 64'd0, 64'd66, 1'b1, 32'hFFFF_FFFF, 1'b0);
    queue_pass(16'h0002, 64'd7, 64'd8, 1'b1, 32'h8000_0000, 1'b1);

    // Fractional milliseconds from a 3 Hz clock, smallest nonzero window.
    start_phase(34'd3, 32'd1, 1'b0);
    queue_pass(16'h0003, 64'd0, 64'd1, 1'b1, 32'd1, 1'b0);
    queue_pass(16'h0003, 64'd0, 64'd2, 1'b1, 32'd0, 1'b1);

    // Random phases; the table fills during the first ones, after that new keys drop.
    start_phase(34'd1000000, 32'h0010_0000, 1'b0);
    queue_random_passes(250);
    start_phase('1, 32'd0, 1'b0);
    queue_random_passes(200);
    start_phase(34'd0, '1, 1'b0);
    queue_random_passes(50);
    start_phase(34'd24000000, $urandom_range(32'h0000_4000, 32'h0400_0000), 1'b1);
    queue_random_passes(300);
    start_phase({2'($urandom_range(0, 3)), $urandom}, $urandom, 1'b0);
    queue_random_passes(300);

    wait_drained();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/pte_pkg.sv
hw/rtl/pte_div.sv
hw/rtl/pte_datapath.sv
hw/rtl/pte_ctrl.sv
hw/rtl/pass_timing_ema_table_unit.sv
hw/rtl/pte_checker.sv
tb/tb_top.sv
